// ===== rtl/hbt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the heartbeat table.
`timescale 1ns / 1ps

package hbt_pkg;

  // Table geometry.
  localparam int SLOTS  = 64;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 3;

  // Configuration.
  localparam logic [CNT_W-1:0] MISS_LIMIT_RESET = 3'd3;
  localparam int               CFG_AW           = 3;
  localparam logic             REG_MISS_LIMIT   = 1'b0;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_ADD       = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_HEARTBEAT = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_EVICTED = 2'd1,
    KIND_ABSENT  = 2'd2,
    KIND_PRESENT = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted input beat
    logic exec;     // execute add, remove or heartbeat and emit its result
    logic t_start;  // start a tick walk at slot zero
    logic t_step;   // process the current slot of the walk
    logic t_end;    // emit the final result of the tick
  } hbt_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a beat this cycle
    logic evict;     // current walk slot is to be evicted
    logic pend_vld;  // an eviction result is being held back
    logic idx_last;  // current walk slot is the final one
  } hbt_sts_t;

endpackage

// ===== rtl/heartbeat_timeout_table.sv =====
// Add, remove and heartbeat capture the input beat, then execute and register their
// result beat once the output register is free. A tick walks one slot per cycle from
// its count memory read port, pausing while a held eviction waits, then emits its final beat.
// Throughput: one item at a time; the next input beat is taken once the last result is
// registered. Reset (synchronous, active low) empties the table at once, no clearing pass.
`timescale 1ns / 1ps

module heartbeat_timeout_table import hbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [5:0] slot, [7:6] zero
  input  logic [1:0]        in_tuser,    // [1:0] command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [5:0] slot_out, [7:6] zero
  output logic [1:0]        out_tuser,   // [1:0] kind
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  hbt_ctl_t          ctl;
  hbt_sts_t          sts;
  cmd_t              in_cmd;
  kind_t             out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]  miss_limit;

  assign in_cmd    = cmd_t'(in_tuser);
  assign out_tuser = out_kind;
  assign out_tdata = {2'b00, out_slot};

  // Configuration registers.
  hbt_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .miss_limit  (miss_limit)
  );

  // Sequencing.
  hbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_cmd),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Table and output register.
  hbt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_cmd),
    .in_slot    (in_tdata[SLOT_W-1:0]),
    .miss_limit (miss_limit),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (out_kind),
    .out_slot   (out_slot),
    .out_last   (out_tlast)
  );

endmodule

// ===== rtl/hbt_regs.sv =====
// APB-style configuration register block holding the miss limit.
`timescale 1ns / 1ps

module hbt_regs import hbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output logic [CNT_W-1:0]  miss_limit
);

  logic [CNT_W-1:0] miss_limit_r;
  logic             wr_en;
  logic             sel_limit;

  // The register index is the word address; byte offset bits are ignored.
  assign sel_limit  = (cfg_paddr[2] == REG_MISS_LIMIT);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Miss limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_limit_r <= MISS_LIMIT_RESET;
    end else if (wr_en && sel_limit) begin
      miss_limit_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // Read data; addresses beyond the register list read as zero.
  always_comb begin
    cfg_prdata = '0;
    if (sel_limit) begin
      cfg_prdata = 32'(miss_limit_r);
    end
  end

  assign miss_limit = miss_limit_r;

endmodule

// ===== rtl/hbt_ctrl.sv =====
// Controller state machine sequencing commands and tick walks.
`timescale 1ns / 1ps

module hbt_ctrl import hbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  cmd_t     in_cmd,
  input  hbt_sts_t sts,
  output hbt_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_TSTART,
    S_TWALK,
    S_TEND
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;
  logic   step_ok;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // A walk step stalls only when it must push out a held eviction beat.
  assign step_ok = !(sts.evict && sts.pend_vld && !sts.out_free);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.load  = 1'b1;
          state_nxt = (in_cmd == CMD_TICK) ? S_TSTART : S_CMD;
        end
      end
      S_CMD: begin
        if (sts.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TSTART: begin
        ctl.t_start = 1'b1;
        state_nxt   = S_TWALK;
      end
      S_TWALK: begin
        if (step_ok) begin
          ctl.t_step = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_TEND;
          end
        end
      end
      S_TEND: begin
        if (sts.out_free) begin
          ctl.t_end = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/hbt_datapath.sv =====
// Datapath: slot valid bits, miss count memory, tick walk index and output register.
`timescale 1ns / 1ps

module hbt_datapath import hbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              in_cmd,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [CNT_W-1:0]  miss_limit,
  input  hbt_ctl_t          ctl,
  output hbt_sts_t          sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output kind_t             out_kind,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_last
);

  // Captured command.
  cmd_t              cmd_r;
  logic [SLOT_W-1:0] slot_r;

  // Table state.
  logic [SLOTS-1:0]  valid_r;
  logic [CNT_W-1:0]  cnt_mem [SLOTS];
  logic [CNT_W-1:0]  rdata_r;

  // Walk state.
  logic [IDX_W-1:0]  idx_r;
  logic              pend_vld_r;
  logic [IDX_W-1:0]  pend_slot_r;

  // Output register.
  logic              out_vld_r;
  kind_t             out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_last_r;

  logic              in_range;
  logic [IDX_W-1:0]  sidx;
  logic              s_valid;
  logic              cur_valid;
  logic              evict;
  logic              idx_last;
  logic              out_free;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic              emit;
  kind_t             e_kind;
  logic [SLOT_W-1:0] e_slot;
  logic              e_last;

  // Slot decode and walk status.
  assign in_range  = ({1'b0, slot_r} < (SLOT_W + 1)'(SLOTS));
  assign sidx      = slot_r[IDX_W-1:0];
  assign s_valid   = valid_r[sidx];
  assign cur_valid = valid_r[idx_r];
  assign evict     = cur_valid && (rdata_r == miss_limit);
  assign idx_last  = (idx_r == IDX_W'(SLOTS - 1));
  assign out_free  = !out_vld_r || out_tready;

  assign sts.out_free = out_free;
  assign sts.evict    = evict;
  assign sts.pend_vld = pend_vld_r;
  assign sts.idx_last = idx_last;

  // Count memory port control: add or heartbeat clears, a walk step increments.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = rdata_r + 1'b1;
    if (ctl.exec && in_range &&
        (((cmd_r == CMD_ADD) && !s_valid) || ((cmd_r == CMD_HEARTBEAT) && s_valid))) begin
      mem_we    = 1'b1;
      mem_waddr = sidx;
      mem_wdata = '0;
    end else if (ctl.t_step && cur_valid && !evict) begin
      mem_we = 1'b1;
    end
  end

  // The walk reads one slot ahead so each step has its count ready.
  assign mem_re    = ctl.t_start || (ctl.t_step && !idx_last);
  assign mem_raddr = ctl.t_start ? '0 : idx_r + 1'b1;

  // Count memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= cnt_mem[mem_raddr];
    end
  end

  // Result beat selection.
  always_comb begin
    emit   = 1'b0;
    e_kind = KIND_DONE;
    e_slot = slot_r;
    e_last = 1'b1;
    if (ctl.exec) begin
      emit = 1'b1;
      if (in_range) begin
        unique case (cmd_r)
          CMD_ADD:       e_kind = s_valid ? KIND_PRESENT : KIND_DONE;
          CMD_REMOVE:    e_kind = KIND_DONE;
          CMD_HEARTBEAT: e_kind = s_valid ? KIND_DONE : KIND_ABSENT;
          CMD_TICK:      e_kind = KIND_DONE;
          default:       e_kind = KIND_DONE;
        endcase
      end
    end else if (ctl.t_step && evict && pend_vld_r) begin
      // A later eviction proves the held one is not the final beat.
      emit   = 1'b1;
      e_kind = KIND_EVICTED;
      e_slot = SLOT_W'(pend_slot_r);
      e_last = 1'b0;
    end else if (ctl.t_end) begin
      emit   = 1'b1;
      e_kind = pend_vld_r ? KIND_EVICTED : KIND_DONE;
      e_slot = pend_vld_r ? SLOT_W'(pend_slot_r) : '0;
    end
  end

  // Control state: valid bits, walk index, held eviction and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      idx_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (ctl.exec && in_range) begin
        if ((cmd_r == CMD_ADD) && !s_valid) begin
          valid_r[sidx] <= 1'b1;
        end else if (cmd_r == CMD_REMOVE) begin
          valid_r[sidx] <= 1'b0;
        end
      end
      if (ctl.t_start) begin
        idx_r      <= '0;
        pend_vld_r <= 1'b0;
      end else if (ctl.t_step) begin
        if (evict) begin
          valid_r[idx_r] <= 1'b0;
          pend_vld_r     <= 1'b1;
        end
        if (!idx_last) begin
          idx_r <= idx_r + 1'b1;
        end
      end else if (ctl.t_end) begin
        pend_vld_r <= 1'b0;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      slot_r <= in_slot;
    end
    if (ctl.t_step && evict) begin
      pend_slot_r <= idx_r;
    end
    if (emit) begin
      out_kind_r <= e_kind;
      out_slot_r <= e_slot;
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_kind   = out_kind_r;
  assign out_slot   = out_slot_r;
  assign out_last   = out_last_r;

endmodule

// ===== rtl/hbt_checker.sv =====
// Port-level assertions for the heartbeat table, bound to the top level.
`timescale 1ns / 1ps

module hbt_checker import hbt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // After an input beat the block is busy until its results are produced.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in progress");

  // Only evictions can be followed by further beats of the same command.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_EVICTED) |-> out_tlast)
    else $error("non-eviction result without last");

  // No new input is taken while a non-final eviction beat waits.
  a_no_accept_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_EVICTED) && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a tick report");

  // Result padding bits stay clear.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:6] == 2'b00))
    else $error("result padding bits set");

endmodule

bind heartbeat_timeout_table hbt_checker u_hbt_checker (.*);
